>>> hdl/pid_dc_motor_sim_step_defines.svh
// Assertion macros for the PID / DC motor tick block.
// Taken in by the top level; no other dependencies.
`ifndef PID_DC_MOTOR_SIM_STEP_DEFINES_SVH
`define PID_DC_MOTOR_SIM_STEP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, disabled in reset
`define PDS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pds: assertion failed");
// next-cycle implication
`define PDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pds: assertion failed");
`else
`define PDS_ASSERT_SAME(lbl, ante, cons)
`define PDS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/pds_pkg.sv
// Shared types, constants and helpers for the PID / DC motor tick block.
// No dependencies.
package pds_pkg;

  localparam int ACC_W  = 54;  // accumulator, holds a sum of three rounded products
  localparam int RES_W  = 52;  // rounded signed product out of the multiplier
  localparam int STEP_W = 5;

  // motor and controller constants, Q16.16 unless noted
  localparam logic signed [31:0] C_INV_LA      = 32'sd539391;
  localparam logic signed [31:0] C_RA_LA       = 32'sd6041179;
  localparam logic signed [31:0] C_KB_LA       = 32'sd690420;
  localparam logic signed [31:0] C_KT_J        = 32'sd3787182;
  localparam logic signed [31:0] C_INV_J       = 32'sd2958736;
  localparam logic signed [31:0] C_B_J         = 32'sd8737;
  localparam logic signed [31:0] C_HALF_DT_Q32 = 32'sd21474836;  // Q0.32
  localparam logic signed [31:0] C_INV_DT      = 32'sd100;       // integer
  localparam logic signed [31:0] C_NEAR_Q16    = 32'sd62259;     // Q0.16

  // register reset values
  localparam logic [30:0]        KP_RESET  = 31'd131072;
  localparam logic [30:0]        KI_RESET  = 31'd131072;
  localparam logic [30:0]        KD_RESET  = 31'd32768;
  localparam logic signed [31:0] REF_RESET = 32'sd655360;

  // register indexes
  localparam logic [1:0] CFG_KP  = 2'd0;
  localparam logic [1:0] CFG_KI  = 2'd1;
  localparam logic [1:0] CFG_KD  = 2'd2;
  localparam logic [1:0] CFG_REF = 2'd3;

  // product shift codes
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_16 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;

  // sequencer steps; multiplier results are used at later steps, once through the multiplier pipeline
  localparam logic [STEP_W-1:0] ST_ERR   = 5'd0;
  localparam logic [STEP_W-1:0] ST_OPS   = 5'd1;
  localparam logic [STEP_W-1:0] ST_TR    = 5'd2;
  localparam logic [STEP_W-1:0] ST_DER   = 5'd3;
  localparam logic [STEP_W-1:0] ST_KP    = 5'd4;
  localparam logic [STEP_W-1:0] ST_INT   = 5'd5;
  localparam logic [STEP_W-1:0] ST_DSAT  = 5'd6;
  localparam logic [STEP_W-1:0] ST_VACC  = 5'd7;
  localparam logic [STEP_W-1:0] ST_THR   = 5'd8;
  localparam logic [STEP_W-1:0] ST_VADD  = 5'd9;
  localparam logic [STEP_W-1:0] ST_VOUT  = 5'd10;
  localparam logic [STEP_W-1:0] ST_DI0   = 5'd11;
  localparam logic [STEP_W-1:0] ST_DI1   = 5'd12;
  localparam logic [STEP_W-1:0] ST_ANG   = 5'd13;
  localparam logic [STEP_W-1:0] ST_DI2   = 5'd14;
  localparam logic [STEP_W-1:0] ST_DW0   = 5'd15;
  localparam logic [STEP_W-1:0] ST_DW1   = 5'd16;
  localparam logic [STEP_W-1:0] ST_DW2   = 5'd17;
  localparam logic [STEP_W-1:0] ST_DWS   = 5'd18;
  localparam logic [STEP_W-1:0] ST_CUR   = 5'd19;
  localparam logic [STEP_W-1:0] ST_SPD   = 5'd22;
  localparam logic [STEP_W-1:0] ST_FIN   = 5'd23;

  typedef struct packed {
    logic              busy;
    logic [STEP_W-1:0] step;
    logic              fin;   // last step completes this cycle
  } pds_ctrl_t;

  function automatic logic signed [ACC_W-1:0] ext32(input logic signed [31:0] v);
    return {{(ACC_W-32){v[31]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_res(input logic signed [RES_W-1:0] v);
    return {{(ACC_W-RES_W){v[RES_W-1]}}, v};
  endfunction

  function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if ((&x[ACC_W-1:31]) || !(|x[ACC_W-1:31])) begin
      r = x[31:0];
    end else if (x[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

>>> hdl/pds_if.sv
// Stream channels of the PID / DC motor tick block: input and result.
// Depends on nothing.
interface pds_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] load_torque;
  modport source (output valid, output load_torque, input ready);
  modport sink   (input valid, input load_torque, output ready);
endinterface

interface pds_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive_voltage;
  logic signed [31:0] armature_current;
  logic signed [31:0] shaft_speed;
  logic signed [31:0] shaft_angle;
  logic [31:0]        tick_count;
  logic               near_target;
  modport source (output valid, output drive_voltage, output armature_current,
                  output shaft_speed, output shaft_angle, output tick_count,
                  output near_target, input ready);
  modport sink   (input valid, input drive_voltage, input armature_current,
                  input shaft_speed, input shaft_angle, input tick_count,
                  input near_target, output ready);
endinterface

>>> hdl/pds_mul_unit.sv
// Shared sign-magnitude multiplier with round-half-away shift, three stages.
// Depends on pds_pkg.
module pds_mul_unit (
  input  logic                        clk,
  input  logic signed [32:0]          op_a,
  input  logic signed [31:0]          op_b,
  input  logic [1:0]                  op_sh,
  output logic signed [pds_pkg::RES_W-1:0] res
);
  import pds_pkg::*;

  logic [32:0]  ma_r;
  logic [31:0]  mb_r;
  logic         neg0_r, neg1_r;
  logic [1:0]   sh0_r, sh1_r;
  logic [64:0]  prod_r;
  logic signed [RES_W-1:0] res_r;

  logic [65:0]      half, rnd, shd;
  logic [RES_W-1:0] mag;
  logic [RES_W-1:0] res_nxt;

  always_comb begin
    unique case (sh1_r)
      SH_16: half = 66'd1 << 15;
      SH_32: half = 66'd1 << 31;
      default: half = '0;
    endcase
    rnd = {1'b0, prod_r} + half;
    unique case (sh1_r)
      SH_16: shd = rnd >> 16;
      SH_32: shd = rnd >> 32;
      default: shd = rnd;
    endcase
    mag     = {1'b0, shd[RES_W-2:0]};
    res_nxt = neg1_r ? (~mag + {{(RES_W-1){1'b0}}, 1'b1}) : mag;
  end

  always_ff @(posedge clk) begin
    // stage 0: magnitudes and sign
    ma_r   <= op_a[32] ? (~op_a + 33'd1) : op_a;
    mb_r   <= op_b[31] ? (~op_b + 32'd1) : op_b;
    neg0_r <= op_a[32] ^ op_b[31];
    sh0_r  <= op_sh;
    // stage 1: product
    prod_r <= {32'd0, ma_r} * {33'd0, mb_r};
    neg1_r <= neg0_r;
    sh1_r  <= sh0_r;
    // stage 2: round, shift, restore sign
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

>>> hdl/pds_seq.sv
// Step sequencer: walks one transaction through the fixed schedule and
// holds on the last step while the result register is occupied. Uses pds_pkg.
module pds_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               out_free,
  output pds_pkg::pds_ctrl_t ctrl
);
  import pds_pkg::*;

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic              fin;

  assign fin = busy_r && (step_r == ST_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= ST_ERR;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= ST_ERR;
    end else if (busy_r) begin
      if (step_r == ST_FIN) begin
        if (out_free) begin
          busy_r <= 1'b0;
        end
      end else begin
        step_r <= step_r + 5'd1;
      end
    end
  end

  assign ctrl.busy = busy_r;
  assign ctrl.step = step_r;
  assign ctrl.fin  = fin;

endmodule

>>> hdl/pid_dc_motor_sim_step.sv
// PID position loop driving a DC motor model, one simulation tick per
// input transaction.
// Channels: in_ch carries the load torque for a tick; out_ch returns the
// drive voltage, new current, speed and angle, the tick count and the
// near-target flag. Gains and reference are written on the cfg_ port
// (index 0 kp, 1 ki, 2 kd, 3 reference); the user must write them only
// while the block is idle, which the block itself does not enforce.
// in_ch.ready is low while a tick is in the schedule of the step sequencer,
// so a new tick is taken only once the last has left it; all fifteen
// products of a tick pass through the single three-stage multiplier.
// A finished result waits in the output register; a new tick may be taken
// meanwhile, and its last step holds until out_ch has taken the previous
// result, so a stalled receiver stalls the block after at most one tick.
// Reset (rst_n low, synchronous) clears motor and controller state, the
// tick count and the output flag and reloads the register defaults; the
// first tick after reset takes the reference as the previous error.
// Depends on pds_pkg, pds_if, pds_mul_unit, pds_seq and the defines header.
`include "pid_dc_motor_sim_step_defines.svh"

module pid_dc_motor_sim_step (
  input  logic        clk,
  input  logic        rst_n,
  pds_in_if.sink      in_ch,
  pds_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import pds_pkg::*;

  pds_ctrl_t ctrl;
  logic      start;
  logic      out_free;

  // configuration
  logic [30:0]        kp_r, ki_r, kd_r;
  logic signed [31:0] ref_r;

  // persistent state
  logic signed [31:0] cur_r, spd_r, ang_r;
  logic signed [31:0] crp_r, srp_r, arp_r;
  logic signed [31:0] error_prev_r, integ_r;
  logic [31:0]        tick_total_r;
  logic               first_r;

  // per-tick working registers
  logic signed [31:0]      tl_r, e_r, eprev_r, d_r, v_r, thr_r, di_r, dw_r, w_new_r;
  logic signed [32:0]      sum_r, dif_r;
  logic signed [ACC_W-1:0] acc_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] o_v_r, o_i_r, o_w_r, o_a_r;
  logic [31:0]        o_tick_r;
  logic               o_near_r;

  logic signed [32:0]      op_a;
  logic signed [31:0]      op_b;
  logic [1:0]              op_sh;
  logic signed [RES_W-1:0] res;
  logic signed [31:0]      res_sat;
  logic                    near;

  assign start    = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !ctrl.busy;
  assign res_sat  = sat32(ext_res(res));

  pds_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  pds_mul_unit u_mul (
    .clk   (clk),
    .op_a  (op_a),
    .op_b  (op_b),
    .op_sh (op_sh),
    .res   (res)
  );

  // multiplier issue schedule
  always_comb begin
    op_a  = '0;
    op_b  = '0;
    op_sh = SH_0;
    if (ctrl.busy) begin
      unique case (ctrl.step)
        ST_TR:   begin op_a = sum_r;         op_b = C_HALF_DT_Q32;  op_sh = SH_32; end
        ST_DER:  begin op_a = dif_r;         op_b = C_INV_DT;       op_sh = SH_0;  end
        ST_KP:   begin op_a = ext33(e_r);    op_b = {1'b0, kp_r};   op_sh = SH_16; end
        ST_INT:  begin op_a = ext33(ref_r);  op_b = C_NEAR_Q16;     op_sh = SH_16; end
        ST_DSAT: begin op_a = ext33(integ_r); op_b = {1'b0, ki_r};  op_sh = SH_16; end
        ST_VACC: begin op_a = ext33(d_r);    op_b = {1'b0, kd_r};   op_sh = SH_16; end
        ST_THR:  begin op_a = ext33(cur_r);  op_b = C_RA_LA;        op_sh = SH_16; end
        ST_VADD: begin op_a = ext33(spd_r);  op_b = C_KB_LA;        op_sh = SH_16; end
        ST_VOUT: begin op_a = sum_r;         op_b = C_HALF_DT_Q32;  op_sh = SH_32; end
        ST_DI0:  begin op_a = ext33(v_r);    op_b = C_INV_LA;       op_sh = SH_16; end
        ST_DI1:  begin op_a = ext33(cur_r);  op_b = C_KT_J;         op_sh = SH_16; end
        ST_ANG:  begin op_a = ext33(tl_r);   op_b = C_INV_J;        op_sh = SH_16; end
        ST_DI2:  begin op_a = ext33(spd_r);  op_b = C_B_J;          op_sh = SH_16; end
        ST_DW1:  begin op_a = sum_r;         op_b = C_HALF_DT_Q32;  op_sh = SH_32; end
        ST_CUR:  begin op_a = sum_r;         op_b = C_HALF_DT_Q32;  op_sh = SH_32; end
        default: begin op_a = '0;            op_b = '0;             op_sh = SH_0;  end
      endcase
    end
  end

  // angle is final by the last step; threshold sense follows reference sign
  assign near = ref_r[31] ? (ang_r <= thr_r) : (ang_r >= thr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= KP_RESET;
      ki_r  <= KI_RESET;
      kd_r  <= KD_RESET;
      ref_r <= REF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KP:  kp_r  <= cfg_wdata[30:0];
        CFG_KI:  ki_r  <= cfg_wdata[30:0];
        CFG_KD:  kd_r  <= cfg_wdata[30:0];
        CFG_REF: ref_r <= cfg_wdata;
        default: ref_r <= ref_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      tl_r <= in_ch.load_torque;
    end
    if (!rst_n) begin
      cur_r        <= '0;
      spd_r        <= '0;
      ang_r        <= '0;
      crp_r        <= '0;
      srp_r        <= '0;
      arp_r        <= '0;
      error_prev_r <= '0;
      integ_r      <= '0;
      tick_total_r <= '0;
      first_r      <= 1'b1;
    end else if (ctrl.busy) begin
      unique case (ctrl.step)
        ST_ERR: begin
          e_r     <= sat32(ext32(ref_r) - ext32(ang_r));
          eprev_r <= first_r ? ref_r : error_prev_r;
        end
        ST_OPS: begin
          sum_r        <= ext33(e_r) + ext33(eprev_r);
          dif_r        <= ext33(e_r) - ext33(eprev_r);
          error_prev_r <= e_r;
          first_r      <= 1'b0;
        end
        ST_KP: begin
          // angle rate is the old speed
          sum_r <= ext33(arp_r) + ext33(spd_r);
          arp_r <= spd_r;
        end
        ST_INT:  integ_r <= sat32(ext32(integ_r) + ext32(res_sat));
        ST_DSAT: d_r     <= res_sat;
        ST_VACC: acc_r   <= ext_res(res);
        ST_THR:  thr_r   <= res[31:0];
        ST_VADD: acc_r   <= acc_r + ext_res(res);
        ST_VOUT: v_r     <= sat32(acc_r + ext_res(res));
        ST_DI0:  acc_r   <= -ext_res(res);
        ST_DI1:  acc_r   <= acc_r - ext_res(res);
        ST_ANG:  ang_r   <= sat32(ext32(ang_r) + ext32(res_sat));
        ST_DI2:  di_r    <= sat32(acc_r + ext_res(res));
        ST_DW0: begin
          acc_r <= ext_res(res);
          sum_r <= ext33(crp_r) + ext33(di_r);
        end
        ST_DW1: begin
          acc_r <= acc_r - ext_res(res);
          crp_r <= di_r;
        end
        ST_DW2: dw_r <= sat32(acc_r - ext_res(res));
        ST_DWS: begin
          sum_r <= ext33(srp_r) + ext33(dw_r);
          srp_r <= dw_r;
        end
        ST_CUR: cur_r   <= sat32(ext32(cur_r) + ext32(res_sat));
        ST_SPD: w_new_r <= sat32(ext32(spd_r) + ext32(res_sat));
        ST_FIN: begin
          if (ctrl.fin) begin
            spd_r        <= w_new_r;
            tick_total_r <= tick_total_r + 32'd1;
          end
        end
        default: acc_r <= acc_r;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctrl.fin) begin
      o_v_r    <= v_r;
      o_i_r    <= cur_r;
      o_w_r    <= w_new_r;
      o_a_r    <= ang_r;
      o_tick_r <= tick_total_r + 32'd1;
      o_near_r <= near;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.drive_voltage    = o_v_r;
  assign out_ch.armature_current = o_i_r;
  assign out_ch.shaft_speed      = o_w_r;
  assign out_ch.shaft_angle      = o_a_r;
  assign out_ch.tick_count       = o_tick_r;
  assign out_ch.near_target      = o_near_r;

  `PDS_ASSERT_NEXT(a_busy_after_accept, start, ctrl.busy && (ctrl.step == ST_ERR))
  `PDS_ASSERT_SAME(a_result_from_fin, $rose(out_valid_r), $past(ctrl.fin))
  `PDS_ASSERT_NEXT(a_tick_matches, ctrl.fin, out_ch.tick_count == tick_total_r)
  `PDS_ASSERT_SAME(a_no_accept_busy, ctrl.busy, !start)

endmodule

>>> tb/pid_dc_motor_sim_step_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pid_dc_motor_sim_step: drives load-torque ticks and gain/reference
// writes, predicts every tick result in a scoreboard class and checks out_ch field by field.
// Depends on pds_pkg, pds_if (pds_in_if, pds_out_if) and the pid_dc_motor_sim_step RTL.
module pid_dc_motor_sim_step_tb;
  import pds_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int RANDOM_PHASES   = 6;
  localparam int TICKS_PER_PHASE = 90;

  typedef struct {
    logic signed [31:0] drive_voltage;
    logic signed [31:0] armature_current;
    logic signed [31:0] shaft_speed;
    logic signed [31:0] shaft_angle;
    logic [31:0]        tick_count;
    logic               near_target;
  } tick_result_t;

  class motor_tick_scoreboard;
    int unsigned  kp_gain, ki_gain, kd_gain;
    int           ref_angle;
    int           current, speed, angle;
    int           current_rate, speed_rate, angle_rate;
    int           err_last, err_integral;
    int unsigned  ticks;
    bit           first_tick;
    tick_result_t expected_q[$];
    int unsigned  mismatches;

    function new();
      kp_gain      = KP_RESET;
      ki_gain      = KI_RESET;
      kd_gain      = KD_RESET;
      ref_angle    = REF_RESET;
      current      = 0;
      speed        = 0;
      angle        = 0;
      current_rate = 0;
      speed_rate   = 0;
      angle_rate   = 0;
      err_last     = 0;
      err_integral = 0;
      ticks        = 0;
      first_tick   = 1'b1;
      mismatches   = 0;
    endfunction

    static function int clamp32(longint x);
      if (x > 64'sd2147483647) return 32'h7fff_ffff;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return int'(x);
    endfunction

    // (a*b) >> s, rounded to nearest, ties away from zero
    static function longint mul_round(longint a, longint b, int unsigned s);
      bit neg;
      longint unsigned ma, mb, p;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      p   = ma * mb;
      p   = (p + (64'd1 << (s - 1))) >> s;
      return neg ? -longint'(p) : longint'(p);
    endfunction

    static function int trap_step(int x, int r0, int r1);
      int inc;
      inc = clamp32(mul_round(longint'(r0) + longint'(r1), C_HALF_DT_Q32, 32));
      return clamp32(longint'(x) + longint'(inc));
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_KP:  kp_gain = {1'b0, data[30:0]};
        CFG_KI:  ki_gain = {1'b0, data[30:0]};
        CFG_KD:  kd_gain = {1'b0, data[30:0]};
        CFG_REF: ref_angle = data;
        default: ;
      endcase
    endfunction

    function void note_tick(logic signed [31:0] torque);
      longint       tl, thr;
      int           eprev, e, d, tr, v, di, dw, da;
      tick_result_t r;
      tl    = torque;
      eprev = first_tick ? ref_angle : err_last;
      e     = clamp32(longint'(ref_angle) - longint'(angle));
      d     = clamp32((longint'(e) - longint'(eprev)) * 100);
      tr    = clamp32(mul_round(longint'(e) + longint'(eprev), C_HALF_DT_Q32, 32));
      err_integral = clamp32(longint'(err_integral) + longint'(tr));
      v = clamp32(mul_round(longint'(kp_gain), e, 16) + mul_round(longint'(ki_gain), err_integral, 16)
                  + mul_round(longint'(kd_gain), d, 16));
      err_last   = e;
      first_tick = 1'b0;

      di = clamp32(mul_round(v, C_INV_LA, 16) - mul_round(current, C_RA_LA, 16)
                   - mul_round(speed, C_KB_LA, 16));
      // friction term uses the old speed
      dw = clamp32(mul_round(current, C_KT_J, 16) - mul_round(tl, C_INV_J, 16)
                   - mul_round(speed, C_B_J, 16));
      da = speed;

      current      = trap_step(current, current_rate, di);
      speed        = trap_step(speed, speed_rate, dw);
      angle        = trap_step(angle, angle_rate, da);
      current_rate = di;
      speed_rate   = dw;
      angle_rate   = da;
      ticks        = ticks + 1;

      thr = mul_round(ref_angle, C_NEAR_Q16, 16);
      r.drive_voltage    = v;
      r.armature_current = current;
      r.shaft_speed      = speed;
      r.shaft_angle      = angle;
      r.tick_count       = ticks;
      r.near_target      = (ref_angle >= 0) ? (longint'(angle) >= thr) : (longint'(angle) <= thr);
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s mismatch: expected %h, actual %h", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result transaction with no tick outstanding");
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      check_field("drive_voltage", exp_r.drive_voltage, got.drive_voltage);
      check_field("armature_current", exp_r.armature_current, got.armature_current);
      check_field("shaft_speed", exp_r.shaft_speed, got.shaft_speed);
      check_field("shaft_angle", exp_r.shaft_angle, got.shaft_angle);
      check_field("tick_count", exp_r.tick_count, got.tick_count);
      check_field("near_target", {31'd0, exp_r.near_target}, {31'd0, got.near_target});
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  pds_in_if  in_ch ();
  pds_out_if out_ch ();

  pid_dc_motor_sim_step i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  motor_tick_scoreboard sb = new();
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // transaction monitors
  always @(posedge clk) begin
    tick_result_t got;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_tick(in_ch.load_torque);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.drive_voltage    = out_ch.drive_voltage;
      got.armature_current = out_ch.armature_current;
      got.shaft_speed      = out_ch.shaft_speed;
      got.shaft_angle      = out_ch.shaft_angle;
      got.tick_count       = out_ch.tick_count;
      got.near_target      = out_ch.near_target;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    bit          rdy;
    int unsigned len;
    forever begin
      rdy = !rx_idle_on || ($urandom_range(0, 2) != 0);
      if (rdy) begin
        len = $urandom_range(1, 6);
      end else if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(20, 60);
      end else begin
        len = $urandom_range(1, 3);
      end
      out_ch.ready <= rdy;
      repeat (len) @(posedge clk);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    // let the monitor note a transaction taken at this very edge
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic drive_tick(logic signed [31:0] torque);
    int unsigned gap;
    in_ch.valid       <= 1'b1;
    in_ch.load_torque <= torque;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic apply_settings(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                                logic [31:0] ref_a);
    logic [1:0]  regs [4];
    logic [31:0] vals [4];
    regs = '{CFG_KP, CFG_KI, CFG_KD, CFG_REF};
    vals = '{kp, ki, kd, ref_a};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_ticks(int n);
    logic signed [31:0] torque;
    for (int i = 0; i < n; i++) begin
      // mostly plausible loads, the rest full-range noise
      if ($urandom_range(0, 4) != 0) begin
        torque = int'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      end else begin
        torque = $urandom;
      end
      drive_tick(torque);
      if ($urandom_range(0, 59) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    logic signed [31:0] reset_torques [8];
    int unsigned        kind;
    reset_torques = '{32'sd0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd1, -32'sd1,
                      32'sd65536, -32'sd65536, 32'sd0};
    tx_idle_on        = 1'b0;
    rx_idle_on        = 1'b0;
    idle_cycles       = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.load_torque <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_KP;
    cfg_wdata         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults, first tick takes the reference as previous error
    foreach (reset_torques[i]) drive_tick(reset_torques[i]);
    wait_drained();

    // saturation everywhere; gain bit 31 must be dropped
    apply_settings(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
    drive_tick(32'sd0);
    drive_tick(32'sh7fff_ffff);
    drive_tick(32'sh8000_0000);
    drive_tick(32'sd0);
    wait_drained();

    apply_settings(32'd0, 32'd0, 32'd0, 32'h8000_0000);
    drive_tick(32'sh7fff_ffff);
    drive_tick(32'sh8000_0000);
    drive_tick(32'sd0);
    wait_drained();

    // zero reference: near-target threshold at zero
    apply_settings(KP_RESET, KI_RESET, KD_RESET, 32'd0);
    repeat (3) drive_tick(32'sd0);
    wait_drained();

    // negative reference flips the near-target comparison
    apply_settings(KP_RESET, KI_RESET, KD_RESET, -32'sd655360);
    repeat (5) drive_tick(32'sd0);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      tx_idle_on = (ph != 0);
      rx_idle_on = (ph != 0);
      kind = (ph == 0) ? 1 : $urandom_range(0, 5);
      case (kind)
        0: apply_settings(KP_RESET, KI_RESET, KD_RESET,
                          int'($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000);
        4: apply_settings($urandom, $urandom, $urandom, $urandom);
        5: apply_settings(32'h7fff_ffff, 32'd0, 32'h7fff_ffff,
                          ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000);
        default: apply_settings($urandom_range(0, 32'h0014_0000), $urandom_range(0, 32'h0005_0000),
                                $urandom_range(0, 32'h0002_0000),
                                int'($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000);
      endcase
      run_random_ticks(TICKS_PER_PHASE);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d expected results never arrived", sb.outstanding());
    end
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
